// ----- rtl/bbc_pkg.sv -----
package bbc_pkg;

  localparam int NUM_BUFFERS_DEF = 32;
  // Entry index width; wide enough for up to 256 entries.
  localparam int IDX_W = 8;
  localparam int CNT_W = 8;
  localparam int DEV_W = 8;
  localparam int BLK_W = 32;
  localparam int SLOT_W = 5;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_GET     = 2'd0,
    OP_RELEASE = 2'd1,
    OP_FLAGS   = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_UNREF    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_INC,
    CMD_ALLOC,
    CMD_RELEASE,
    CMD_FLAGS
  } cmd_kind_t;

  typedef logic [IDX_W-1:0] idx_t;

  // Request fields held steady for the whole scan.
  typedef struct packed {
    logic [DEV_W-1:0] device;
    logic [BLK_W-1:0] block_number;
    idx_t             slot;
  } req_t;

  // Scan token handed from cell to cell.
  typedef struct packed {
    logic             valid;
    logic             found;
    idx_t             f_idx;
    idx_t             f_rank;
    logic [CNT_W-1:0] f_cnt;
    logic             f_valid;
    logic             v_ok;
    idx_t             v_idx;
    idx_t             v_rank;
    logic             t_hit;
    logic [CNT_W-1:0] t_cnt;
    idx_t             t_rank;
  } token_t;

  // Update broadcast to every cell.
  typedef struct packed {
    logic             valid;
    cmd_kind_t        kind;
    idx_t             idx;
    logic [DEV_W-1:0] device;
    logic [BLK_W-1:0] block_number;
    logic             new_valid;
    logic             new_dirty;
    logic             mru;
    idx_t             rank;
  } cmd_t;

endpackage

// ----- rtl/bbc_if.sv -----
interface bbc_req_if;
  import bbc_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [DEV_W-1:0]   device;
  logic [BLK_W-1:0]   block_number;
  logic [SLOT_W-1:0]  slot;
  logic               new_valid;
  logic               new_dirty;
  modport source (output valid, op, device, block_number, slot, new_valid, new_dirty,
                  input ready);
  modport sink (input valid, op, device, block_number, slot, new_valid, new_dirty,
                output ready);
endinterface

interface bbc_rsp_if;
  import bbc_pkg::*;
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] result_slot;
  logic              hit;
  logic              needs_read;
  logic [1:0]        status;
  modport source (output valid, result_slot, hit, needs_read, status, input ready);
  modport sink (input valid, result_slot, hit, needs_read, status, output ready);
endinterface

// ----- rtl/bbc_cell.sv -----
module bbc_cell import bbc_pkg::*; #(
  parameter int NUM_BUFFERS = NUM_BUFFERS_DEF,
  parameter int IDX = 0
) (
  input  logic   clk,
  input  logic   rst,
  input  req_t   req,
  input  token_t tok_in,
  output token_t tok_out,
  input  cmd_t   cmd
);

  localparam idx_t MY_IDX = IDX_W'(IDX);
  localparam idx_t RANK_RST = IDX_W'(NUM_BUFFERS - 1 - IDX);

  logic [DEV_W-1:0] tag_device;
  logic [BLK_W-1:0] tag_block;
  logic [CNT_W-1:0] ref_count;
  logic             valid_bit;
  logic             dirty_bit;
  logic             has_tag;
  idx_t             rank;
  token_t           tok_next;

  // Fold this entry into the running best-so-far.
  always_comb begin
    tok_next = tok_in;
    if (has_tag && tag_device == req.device && tag_block == req.block_number &&
        (!tok_in.found || rank < tok_in.f_rank)) begin
      tok_next.found   = 1'b1;
      tok_next.f_idx   = MY_IDX;
      tok_next.f_rank  = rank;
      tok_next.f_cnt   = ref_count;
      tok_next.f_valid = valid_bit;
    end
    if (ref_count == '0 && !dirty_bit && (!tok_in.v_ok || rank > tok_in.v_rank)) begin
      tok_next.v_ok   = 1'b1;
      tok_next.v_idx  = MY_IDX;
      tok_next.v_rank = rank;
    end
    if (req.slot == MY_IDX) begin
      tok_next.t_hit  = 1'b1;
      tok_next.t_cnt  = ref_count;
      tok_next.t_rank = rank;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_device <= '0;
      tag_block  <= '0;
      ref_count  <= '0;
      valid_bit  <= 1'b0;
      dirty_bit  <= 1'b0;
      has_tag    <= 1'b0;
      rank       <= RANK_RST;
    end else if (cmd.valid) begin
      if (cmd.idx == MY_IDX) begin
        unique case (cmd.kind)
          CMD_INC: begin
            ref_count <= ref_count + 1'b1;
          end
          CMD_ALLOC: begin
            tag_device <= cmd.device;
            tag_block  <= cmd.block_number;
            has_tag    <= 1'b1;
            valid_bit  <= 1'b0;
            dirty_bit  <= 1'b0;
            ref_count  <= CNT_W'(1);
          end
          CMD_RELEASE: begin
            ref_count <= ref_count - 1'b1;
            if (cmd.mru) begin
              rank <= '0;
            end
          end
          CMD_FLAGS: begin
            valid_bit <= cmd.new_valid;
            dirty_bit <= cmd.new_dirty;
          end
        endcase
      end else if (cmd.kind == CMD_RELEASE && cmd.mru && rank < cmd.rank) begin
        rank <= rank + 1'b1;
      end
    end
  end

endmodule

// ----- rtl/block_buffer_cache_lru_top.sv -----
// LRU buffer cache controller for NUM_BUFFERS disk block entries. Each request
// (get, release, set flags) passes from accept to result through these steps:
// a search token walks the row of entry cells one cell per cycle, then the
// outcome is registered and the cells apply the update, after which the result
// beat is offered. One request is in flight at a time; the next is accepted the
// cycle after the result beat is taken.
module block_buffer_cache_lru_top import bbc_pkg::*; #(
  parameter int NUM_BUFFERS = NUM_BUFFERS_DEF
) (
  input logic      clk,
  input logic      rst,
  bbc_req_if.sink  req,
  bbc_rsp_if.source rsp
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SETTLE, S_OUT} state_t;

  state_t            state;
  logic [1:0]        op;
  req_t              req_q;
  logic [SLOT_W-1:0] slot_q;
  logic              new_valid;
  logic              new_dirty;
  logic              start;
  cmd_t              cmd;
  cmd_t              cmd_next;
  token_t            tok_last;
  token_t            tok_start;
  token_t            tok [NUM_BUFFERS+1];
  logic [SLOT_W-1:0] result_slot, result_slot_next;
  logic              hit, hit_next;
  logic              needs_read, needs_read_next;
  status_t           status, status_next;

  // Launch an empty token into the first cell.
  always_comb begin
    tok_start       = '0;
    tok_start.valid = start;
  end
  assign tok[0]   = tok_start;
  assign tok_last = tok[NUM_BUFFERS];

  for (genvar g = 0; g < NUM_BUFFERS; g++) begin : g_cell
    bbc_cell #(.NUM_BUFFERS(NUM_BUFFERS), .IDX(g)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .req    (req_q),
      .tok_in (tok[g]),
      .tok_out(tok[g+1]),
      .cmd    (cmd)
    );
  end

  // Decide the outcome from the finished token.
  always_comb begin
    cmd_next              = '0;
    cmd_next.device       = req_q.device;
    cmd_next.block_number = req_q.block_number;
    cmd_next.new_valid    = new_valid;
    cmd_next.new_dirty    = new_dirty;
    result_slot_next      = slot_q;
    hit_next              = 1'b0;
    needs_read_next       = 1'b0;
    status_next           = ST_OK;
    unique case (op_t'(op))
      OP_GET: begin
        if (tok_last.found) begin
          // Hit: bump the count unless it is saturated.
          result_slot_next = tok_last.f_idx[SLOT_W-1:0];
          hit_next         = 1'b1;
          needs_read_next  = !tok_last.f_valid;
          if (tok_last.f_cnt == CNT_MAX) begin
            status_next = ST_OVERFLOW;
          end else begin
            cmd_next.valid = 1'b1;
            cmd_next.kind  = CMD_INC;
            cmd_next.idx   = tok_last.f_idx;
          end
        end else if (tok_last.v_ok) begin
          // Miss: retag the least recent free, clean entry.
          result_slot_next = tok_last.v_idx[SLOT_W-1:0];
          needs_read_next  = 1'b1;
          cmd_next.valid   = 1'b1;
          cmd_next.kind    = CMD_ALLOC;
          cmd_next.idx     = tok_last.v_idx;
        end else begin
          result_slot_next = '0;
          status_next      = ST_NO_FREE;
        end
      end
      OP_RELEASE: begin
        if (!tok_last.t_hit || tok_last.t_cnt == '0) begin
          status_next = ST_UNREF;
        end else begin
          // Drop one reference; if it was the last, move the entry to the front.
          cmd_next.valid = 1'b1;
          cmd_next.kind  = CMD_RELEASE;
          cmd_next.idx   = req_q.slot;
          cmd_next.mru   = (tok_last.t_cnt == CNT_W'(1));
          cmd_next.rank  = tok_last.t_rank;
        end
      end
      OP_FLAGS: begin
        if (tok_last.t_hit) begin
          cmd_next.valid = 1'b1;
          cmd_next.kind  = CMD_FLAGS;
          cmd_next.idx   = req_q.slot;
        end
      end
      OP_NONE: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      start <= 1'b0;
      cmd   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          start <= req.valid;
          if (req.valid) begin
            // Hold the request for the whole scan.
            op                 <= req.op;
            req_q.device       <= req.device;
            req_q.block_number <= req.block_number;
            req_q.slot         <= IDX_W'(req.slot);
            slot_q             <= req.slot;
            new_valid          <= req.new_valid;
            new_dirty          <= req.new_dirty;
            state              <= S_SCAN;
          end
        end
        S_SCAN: begin
          start <= 1'b0;
          if (tok_last.valid) begin
            cmd         <= cmd_next;
            result_slot <= result_slot_next;
            hit         <= hit_next;
            needs_read  <= needs_read_next;
            status      <= status_next;
            state       <= S_SETTLE;
          end
        end
        S_SETTLE: begin
          // Cells apply the update in this cycle; drop it afterwards.
          cmd.valid <= 1'b0;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (rsp.ready) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = (state == S_OUT);
  assign rsp.result_slot = result_slot;
  assign rsp.hit         = hit;
  assign rsp.needs_read  = needs_read;
  assign rsp.status      = status;

`ifndef SYNTHESIS
  // An accepted beat closes the request side until its result is taken.
  a_accept_closes: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while busy");
  // Updates are single-cycle pulses.
  a_cmd_pulse: assert property (@(posedge clk) disable iff (rst)
    cmd.valid |=> !cmd.valid)
    else $error("update held for more than one cycle");
  // The token leaves the last cell only while a scan is running.
  a_token_in_scan: assert property (@(posedge clk) disable iff (rst)
    tok_last.valid |-> state == S_SCAN)
    else $error("stray search token");
  // No update lands while a result is on offer.
  a_no_cmd_at_out: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !cmd.valid)
    else $error("update overlaps result beat");
`endif

endmodule

// ----- dv/bbc_lru_checker.sv -----
`timescale 1ns / 1ps

module bbc_lru_checker import bbc_pkg::*; #(
  parameter int NUM_BUFFERS = NUM_BUFFERS_DEF
) (
  input logic clk,
  input logic rst,
  bbc_req_if  req,
  bbc_rsp_if  rsp,
  output int  errors,
  output int  pending
);

  typedef struct packed {
    logic [SLOT_W-1:0] result_slot;
    logic              hit;
    logic              needs_read;
    status_t           status;
  } lookup_result_t;

  logic [DEV_W-1:0] ent_device [NUM_BUFFERS];
  logic [BLK_W-1:0] ent_block  [NUM_BUFFERS];
  logic [CNT_W-1:0] ent_refs   [NUM_BUFFERS];
  logic             ent_valid  [NUM_BUFFERS];
  logic             ent_dirty  [NUM_BUFFERS];
  logic             ent_tagged [NUM_BUFFERS];
  int unsigned      ent_rank   [NUM_BUFFERS];

  lookup_result_t expected_results[$];

  assign pending = expected_results.size();

  function automatic lookup_result_t cache_access(input op_t op, input logic [DEV_W-1:0] dev,
                                                  input logic [BLK_W-1:0] blk,
                                                  input logic [SLOT_W-1:0] slot,
                                                  input logic nv, input logic nd);
    lookup_result_t r;
    int found;
    int victim;
    int unsigned old_rank;
    found  = -1;
    victim = -1;
    r = '{result_slot: slot, hit: 1'b0, needs_read: 1'b0, status: ST_OK};
    case (op)
      OP_GET: begin
        for (int i = 0; i < NUM_BUFFERS; i++)
          if (ent_tagged[i] && ent_device[i] == dev && ent_block[i] == blk)
            if (found < 0 || ent_rank[i] < ent_rank[found]) found = i;
        if (found >= 0) begin
          if (ent_refs[found] == CNT_MAX) r.status = ST_OVERFLOW;
          else ent_refs[found]++;
          r.result_slot = found[SLOT_W-1:0];
          r.hit         = 1'b1;
          r.needs_read  = !ent_valid[found];
        end else begin
          for (int i = 0; i < NUM_BUFFERS; i++)
            if (ent_refs[i] == 0 && !ent_dirty[i])
              if (victim < 0 || ent_rank[i] > ent_rank[victim]) victim = i;
          if (victim < 0) begin
            r.result_slot = '0;
            r.status      = ST_NO_FREE;
          end else begin
            ent_device[victim] = dev;
            ent_block[victim]  = blk;
            ent_tagged[victim] = 1'b1;
            ent_valid[victim]  = 1'b0;
            ent_dirty[victim]  = 1'b0;
            ent_refs[victim]   = CNT_W'(1);
            r.result_slot = victim[SLOT_W-1:0];
            r.needs_read  = 1'b1;
          end
        end
      end
      OP_RELEASE: begin
        if (slot >= NUM_BUFFERS || ent_refs[slot] == 0) begin
          r.status = ST_UNREF;
        end else begin
          ent_refs[slot]--;
          if (ent_refs[slot] == 0) begin
            // move to the front of the recency order
            old_rank = ent_rank[slot];
            for (int i = 0; i < NUM_BUFFERS; i++)
              if (ent_rank[i] < old_rank) ent_rank[i]++;
            ent_rank[slot] = 0;
          end
        end
      end
      OP_FLAGS: begin
        if (slot < NUM_BUFFERS) begin
          ent_valid[slot] = nv;
          ent_dirty[slot] = nd;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    lookup_result_t want;
    if (rst) begin
      errors <= 0;
      expected_results.delete();
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        ent_device[i] = '0;
        ent_block[i]  = '0;
        ent_refs[i]   = '0;
        ent_valid[i]  = 1'b0;
        ent_dirty[i]  = 1'b0;
        ent_tagged[i] = 1'b0;
        ent_rank[i]   = NUM_BUFFERS - 1 - i;
      end
    end else begin
      if (req.valid && req.ready)
        expected_results.push_back(cache_access(op_t'(req.op), req.device, req.block_number,
                                                req.slot, req.new_valid, req.new_dirty));
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat slot=%0d hit=%0d needs_read=%0d status=%0d",
                   $time, rsp.result_slot, rsp.hit, rsp.needs_read, rsp.status);
          errors <= errors + 1;
        end else begin
          want = expected_results.pop_front();
          if (want.result_slot !== rsp.result_slot || want.hit !== rsp.hit ||
              want.needs_read !== rsp.needs_read || want.status !== rsp.status) begin
            $display("%0t: mismatch expected slot=%0d hit=%0d needs_read=%0d status=%0d",
                     $time, want.result_slot, want.hit, want.needs_read, want.status);
            $display("%0t:          actual   slot=%0d hit=%0d needs_read=%0d status=%0d",
                     $time, rsp.result_slot, rsp.hit, rsp.needs_read, rsp.status);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// ----- dv/block_buffer_cache_lru_top_tb.sv -----
`timescale 1ns / 1ps

module block_buffer_cache_lru_top_tb;
  import bbc_pkg::*;

  localparam int NBUF        = NUM_BUFFERS_DEF;
  localparam int RAND_ITEMS  = 1473;
  localparam int IDLE_LIMIT  = 3000;  // longest stall plus a request plus a gap, several times

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors;
  int   pending;
  int   idle_cycles;
  int   items_sent;

  bbc_req_if req ();
  bbc_rsp_if rsp ();

  block_buffer_cache_lru_top #(.NUM_BUFFERS(NBUF)) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  bbc_lru_checker #(.NUM_BUFFERS(NBUF)) u_checker (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .errors  (errors),
    .pending (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Slots currently holding a reference, learned from get results so that
  // most releases and flag writes target live entries.
  op_t                 ops_in_flight[$];
  logic [SLOT_W-1:0]   held_slots[$];

  always @(posedge clk) begin
    op_t sent_op;
    if (!rst) begin
      if (req.valid && req.ready) ops_in_flight.push_back(op_t'(req.op));
      if (rsp.valid && rsp.ready && ops_in_flight.size() > 0) begin
        sent_op = ops_in_flight.pop_front();
        if (sent_op == OP_GET && rsp.status == ST_OK) held_slots.push_back(rsp.result_slot);
      end
    end
  end

  // Watchdog: count cycles with no beat on either channel.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Receiver: segments of always-ready, half-ready and mostly-stalled,
  // plus one long hold-off while the sender keeps offering beats.
  initial begin
    int mode;
    int seg_left;
    bit long_done;
    rsp.ready <= 1'b0;
    long_done = 1'b0;
    seg_left  = 0;
    mode      = 0;
    @(posedge clk iff !rst);
    forever begin
      if (!long_done && items_sent >= 400) begin
        long_done = 1'b1;
        rsp.ready <= 1'b0;
        repeat (600) @(posedge clk);
      end
      if (seg_left == 0) begin
        mode     = $urandom_range(0, 2);
        seg_left = $urandom_range(20, 200);
      end
      seg_left--;
      case (mode)
        0:       rsp.ready <= 1'b1;
        1:       rsp.ready <= 1'($urandom_range(0, 1));
        default: rsp.ready <= ($urandom_range(0, 4) == 0);
      endcase
      @(posedge clk);
    end
  end

  int burst_left;

  // Offer one beat and hold it until accepted; close a burst, sometimes with a gap.
  task automatic send_item(input op_t op, input logic [DEV_W-1:0] dev,
                           input logic [BLK_W-1:0] blk, input logic [SLOT_W-1:0] slot,
                           input logic nv, input logic nd);
    int gap;
    req.valid        <= 1'b1;
    req.op           <= op;
    req.device       <= dev;
    req.block_number <= blk;
    req.slot         <= slot;
    req.new_valid    <= nv;
    req.new_dirty    <= nd;
    do @(posedge clk); while (!(req.valid && req.ready));
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic logic [SLOT_W-1:0] pick_slot(input bit take);
    int k;
    logic [SLOT_W-1:0] s;
    if (held_slots.size() > 0 && $urandom_range(0, 99) < 85) begin
      k = $urandom_range(0, held_slots.size() - 1);
      s = held_slots[k];
      if (take) held_slots.delete(k);
      return s;
    end
    return SLOT_W'($urandom_range(0, NBUF - 1));
  endfunction

  // Random traffic over a small tag pool so hits, evictions and exhaustion
  // all recur; the get share swings between phases to fill and drain.
  task automatic random_item(input int n);
    int roll;
    int get_pct;
    int rel_pct;
    logic [DEV_W-1:0] dev;
    logic [BLK_W-1:0] blk;
    get_pct = ((n / 250) % 2 == 0) ? 60 : 30;
    rel_pct = ((n / 250) % 2 == 0) ? 17 : 45;
    roll = $urandom_range(0, 99);
    dev  = ($urandom_range(0, 9) < 7) ? DEV_W'($urandom_range(0, 3)) : DEV_W'($urandom);
    blk  = ($urandom_range(0, 9) < 7) ? BLK_W'($urandom_range(0, 23)) : BLK_W'($urandom);
    if (roll < get_pct)
      send_item(OP_GET, dev, blk, SLOT_W'($urandom), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    else if (roll < get_pct + rel_pct)
      send_item(OP_RELEASE, DEV_W'($urandom), BLK_W'($urandom), pick_slot(1'b1),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    else if (roll < 96)
      send_item(OP_FLAGS, DEV_W'($urandom), BLK_W'($urandom), pick_slot(1'b0),
                $urandom_range(0, 9) < 8, $urandom_range(0, 9) < 2);
    else
      send_item(OP_NONE, DEV_W'($urandom), BLK_W'($urandom), SLOT_W'($urandom),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int n;
    req.valid        <= 1'b0;
    req.op           <= OP_NONE;
    req.device       <= '0;
    req.block_number <= '0;
    req.slot         <= '0;
    req.new_valid    <= 1'b0;
    req.new_dirty    <= 1'b0;
    items_sent = 0;
    burst_left = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: miss into an empty cache, extreme tags, hits, flag writes,
    // releases of unreferenced slots, and the unused op.
    send_item(OP_GET, '0, '0, '0, 1'b0, 1'b0);
    send_item(OP_GET, '1, '1, '1, 1'b1, 1'b1);
    send_item(OP_GET, '0, '0, '0, 1'b0, 1'b0);
    send_item(OP_FLAGS, '0, '0, 5'd31, 1'b1, 1'b0);
    send_item(OP_GET, '0, '0, '0, 1'b0, 1'b0);
    send_item(OP_FLAGS, '1, '1, 5'd30, 1'b1, 1'b1);
    send_item(OP_RELEASE, '0, '0, 5'd5, 1'b0, 1'b0);
    send_item(OP_RELEASE, '0, '0, 5'd31, 1'b0, 1'b0);
    send_item(OP_RELEASE, '0, '0, 5'd31, 1'b0, 1'b0);
    send_item(OP_RELEASE, '0, '0, 5'd31, 1'b0, 1'b0);
    send_item(OP_RELEASE, '0, '0, 5'd31, 1'b0, 1'b0);
    send_item(OP_RELEASE, '0, '0, 5'd30, 1'b0, 1'b0);
    send_item(OP_GET, 8'h5A, 32'hA5A5_5A5A, '0, 1'b0, 1'b0);
    send_item(OP_GET, '0, '0, '0, 1'b0, 1'b0);
    send_item(OP_NONE, '1, '1, 5'd17, 1'b1, 1'b1);
    send_item(OP_FLAGS, '0, '0, 5'd30, 1'b0, 1'b0);
    send_item(OP_GET, '1, '1, '0, 1'b0, 1'b0);
    held_slots.delete();

    // Hammer one tag past the count limit, then let random releases drain it.
    for (n = 0; n < 260; n++) send_item(OP_GET, 8'd7, 32'h0000_ABCD, '0, 1'b0, 1'b0);

    for (n = 0; n < RAND_ITEMS; n++) begin
      // drain fully once mid-run
      if (n == 900) begin
        req.valid <= 1'b0;
        @(posedge clk iff pending == 0);
      end
      random_item(n);
    end
    req.valid <= 1'b0;

    @(posedge clk iff pending == 0);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
